[rtl/core/tsw_pkg.sv]
// Shared types, register indexes and coordinate wrap function for the
// bilinear texture sampler. No dependencies.
package tsw_pkg;

  localparam int COORD_ONE  = 4096;
  localparam int COORD_HALF = 2048;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] WRAP_REPEAT = 2'd0;
  localparam logic [1:0] WRAP_MIRROR = 2'd1;
  localparam logic [1:0] WRAP_CLAMP  = 2'd2;

  localparam logic FILTER_NEAREST  = 1'b0;
  localparam logic FILTER_BILINEAR = 1'b1;

  localparam logic [1:0] REG_TEX_WIDTH   = 2'd0;
  localparam logic [1:0] REG_TEX_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_WRAP_MODE   = 2'd2;
  localparam logic [1:0] REG_FILTER_MODE = 2'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] coord_u;
    logic [15:0] coord_v;
    logic [7:0]  texel_col;
    logic [7:0]  texel_row;
    logic [31:0] texel_value;
  } req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rsp_t;

  // Wrapped coordinate in [0, 4096]
  function automatic logic [12:0] wrap_coord(input logic [15:0] c, input logic [1:0] mode);
    logic signed [13:0] m;
    logic [12:0]        r;
    m = $signed({1'b0, c[12:0]}) - 14'sd4096;
    case (mode)
      WRAP_REPEAT: begin
        r = {1'b0, c[11:0]};
      end
      WRAP_MIRROR: begin
        r = (m < 0) ? 13'(-m) : 13'(m);
      end
      default: begin
        if (c[15]) begin
          r = '0;
        end else if (c > 16'd4096) begin
          r = 13'd4096;
        end else begin
          r = c[12:0];
        end
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/core/tsw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/tsw_coord.sv]
// Coordinate stages: wrap (stage A), scale to texel space (stage B).
// Depends on tsw_pkg.
module tsw_coord #(
  parameter int SZW = 9,
  parameter int PW  = 23
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tsw_pkg::req_t         in_req,
  input  logic [1:0]            wrap_mode,
  input  logic [SZW-1:0]        size_u,
  input  logic [SZW-1:0]        size_v,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_op,
  output logic signed [PW-1:0]  out_pu,
  output logic signed [PW-1:0]  out_pv,
  output logic [7:0]            out_col,
  output logic [7:0]            out_row,
  output logic [31:0]           out_value
);
  import tsw_pkg::*;

  logic        a_valid, a_op;
  logic [12:0] a_wu, a_wv;
  logic [7:0]  a_col, a_row;
  logic [31:0] a_value;
  logic        a_en, b_en;
  logic [12+SZW:0] prod_u, prod_v;

  assign b_en     = !out_valid || out_ready;
  assign a_en     = !a_valid || b_en;
  assign in_ready = a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= in_valid;
    end
    if (a_en) begin
      a_op    <= in_req.op;
      a_wu    <= wrap_coord(in_req.coord_u, wrap_mode);
      a_wv    <= wrap_coord(in_req.coord_v, wrap_mode);
      a_col   <= in_req.texel_col;
      a_row   <= in_req.texel_row;
      a_value <= in_req.texel_value;
    end
  end

  assign prod_u = (13 + SZW)'(a_wu) * (13 + SZW)'(size_u);
  assign prod_v = (13 + SZW)'(a_wv) * (13 + SZW)'(size_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_en) begin
      out_valid <= a_valid;
    end
    if (b_en) begin
      out_op    <= a_op;
      out_pu    <= $signed(prod_u) - $signed(PW'(COORD_HALF));
      out_pv    <= $signed(prod_v) - $signed(PW'(COORD_HALF));
      out_col   <= a_col;
      out_row   <= a_row;
      out_value <= a_value;
    end
  end

endmodule

[rtl/core/tsw_fetch.sv]
// Texel index selection and four-bank texel store (stage C, read in stage D).
// Depends on tsw_pkg and tsw_ram.
module tsw_fetch #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int WEIGHT_BITS = 8,
  parameter int SZW         = 9,
  parameter int PW          = 23
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic signed [PW-1:0]        in_pu,
  input  logic signed [PW-1:0]        in_pv,
  input  logic [7:0]                  in_col,
  input  logic [7:0]                  in_row,
  input  logic [31:0]                 in_value,
  input  logic                        filter_mode,
  input  logic [SZW-1:0]              size_u,
  input  logic [SZW-1:0]              size_v,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [3:0][31:0]            out_quad,
  output logic [WEIGHT_BITS-1:0]      out_fx,
  output logic [WEIGHT_BITS-1:0]      out_fy
);
  import tsw_pkg::*;

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int IW  = (CW > RW) ? CW : RW;
  localparam int CAW = (CW > 1) ? CW - 1 : 1;
  localparam int RAW = (RW > 1) ? RW - 1 : 1;
  localparam int AW  = CAW + RAW;
  localparam int FW  = PW - 12;

  typedef struct packed {
    logic [IW-1:0]          i0;
    logic [IW-1:0]          i1;
    logic [WEIGHT_BITS-1:0] wt;
  } axis_t;

  function automatic logic [IW-1:0] clampf(input logic signed [FW-1:0] f,
                                           input logic signed [FW-1:0] lim);
    logic [IW-1:0] r;
    if (f < 0) begin
      r = '0;
    end else if (f > lim) begin
      r = IW'(lim);
    end else begin
      r = IW'(f);
    end
    return r;
  endfunction

  function automatic axis_t split(input logic signed [PW-1:0] p, input logic [SZW-1:0] size,
                                  input logic bil);
    logic signed [FW-1:0] f, f1, nf, lim;
    axis_t r;
    lim = $signed(FW'(size - 1'b1));
    f   = FW'(p >>> 12);
    f1  = f + $signed({{(FW-1){1'b0}}, p[11:0] != 12'd0});
    nf  = (p < 0) ? '0 : FW'((p + $signed(PW'(COORD_HALF))) >>> 12);
    if (bil) begin
      r.i0 = clampf(f, lim);
      r.i1 = clampf(f1, lim);
      r.wt = (p < 0) ? '0 : p[11 -: WEIGHT_BITS];
    end else begin
      r.i0 = clampf(nf, lim);
      r.i1 = r.i0;
      r.wt = '0;
    end
    return r;
  endfunction

  axis_t         xs, ys;
  logic [IW-1:0] colb [2];
  logic [IW-1:0] rowb [2];
  logic          d_en, take, wr_ok;
  logic [1:0]    wbank;
  logic [AW-1:0] waddr;
  logic [31:0]   rd [4];
  logic          d_x0p, d_x1p, d_y0p, d_y1p;

  assign d_en     = !out_valid || out_ready;
  assign in_ready = d_en;
  assign take     = in_valid && d_en;

  assign xs = split(in_pu, size_u, filter_mode == FILTER_BILINEAR);
  assign ys = split(in_pv, size_v, filter_mode == FILTER_BILINEAR);

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      colb[b] = (xs.i0[0] == b[0]) ? xs.i0 : xs.i1;
      rowb[b] = (ys.i0[0] == b[0]) ? ys.i0 : ys.i1;
    end
  end

  assign wr_ok = (32'(in_col) < 32'(MAX_WIDTH)) && (32'(in_row) < 32'(MAX_HEIGHT));
  assign wbank = {in_row[0], in_col[0]};
  assign waddr = {RAW'(in_row >> 1), CAW'(in_col >> 1)};

  for (genvar g = 0; g < 4; g++) begin : g_bank
    tsw_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
      .clk   (clk),
      .we    (take && in_op == OP_WRITE && wr_ok && wbank == 2'(g)),
      .waddr (waddr),
      .wdata (in_value),
      .re    (d_en),
      .raddr ({RAW'(rowb[g / 2] >> 1), CAW'(colb[g % 2] >> 1)}),
      .rdata (rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_en) begin
      out_valid <= in_valid && in_op == OP_SAMPLE;
    end
    if (d_en) begin
      out_fx <= xs.wt;
      out_fy <= ys.wt;
      d_x0p  <= xs.i0[0];
      d_x1p  <= xs.i1[0];
      d_y0p  <= ys.i0[0];
      d_y1p  <= ys.i1[0];
    end
  end

  // quad order: t00, t10, t01, t11
  assign out_quad[0] = rd[{d_y0p, d_x0p}];
  assign out_quad[1] = rd[{d_y0p, d_x1p}];
  assign out_quad[2] = rd[{d_y1p, d_x0p}];
  assign out_quad[3] = rd[{d_y1p, d_x1p}];

endmodule

[rtl/core/tsw_blend.sv]
// Horizontal blend (stage E), vertical blend and rounding into the result
// register (stage F). Depends on tsw_pkg.
module tsw_blend #(
  parameter int WEIGHT_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [3:0][31:0]       in_quad,
  input  logic [WEIGHT_BITS-1:0] in_fx,
  input  logic [WEIGHT_BITS-1:0] in_fy,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tsw_pkg::rsp_t          out_rsp
);
  import tsw_pkg::*;

  localparam int WB = WEIGHT_BITS;
  localparam int HW = 8 + WB + 1;
  localparam int SUMW = 9 + 2 * WB + 1;

  logic          e_valid, e_en, f_en;
  logic [WB:0]   nfx, nfy;
  logic [HW-1:0] e_top [4];
  logic [HW-1:0] e_bot [4];
  logic [WB-1:0] e_fy;
  logic [SUMW-1:0] sum [4];
  logic [7:0]    chan [4];

  assign f_en     = !out_valid || out_ready;
  assign e_en     = !e_valid || f_en;
  assign in_ready = e_en;
  assign nfx      = (WB + 1)'(1 << WB) - {1'b0, in_fx};
  assign nfy      = (WB + 1)'(1 << WB) - {1'b0, e_fy};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_en) begin
      e_valid <= in_valid;
    end
    if (e_en) begin
      e_fy <= in_fy;
      for (int c = 0; c < 4; c++) begin
        e_top[c] <= HW'(in_quad[0][8*c +: 8]) * HW'(nfx)
                  + HW'(in_quad[1][8*c +: 8]) * HW'(in_fx);
        e_bot[c] <= HW'(in_quad[2][8*c +: 8]) * HW'(nfx)
                  + HW'(in_quad[3][8*c +: 8]) * HW'(in_fx);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c]  = SUMW'(e_top[c]) * SUMW'(nfy) + SUMW'(e_bot[c]) * SUMW'(e_fy)
              + SUMW'(1 << (2 * WB - 1));
      chan[c] = sum[c][2 * WB +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (f_en) begin
      out_valid <= e_valid;
    end
    if (f_en) begin
      out_rsp.red   <= chan[0];
      out_rsp.green <= chan[1];
      out_rsp.blue  <= chan[2];
      out_rsp.alpha <= chan[3];
    end
  end

endmodule

[rtl/core/texture_sampler_wrap_bilinear.sv]
// Top level of the texture sampler: configuration registers and the
// coordinate, fetch and blend pipeline. Depends on tsw_pkg and all tsw_ modules.
//
// Texture unit with repeat, mirror or clamp wrap and nearest or bilinear
// filtering over an RGBA8 store of MAX_WIDTH x MAX_HEIGHT texels. A request
// with op write stores one texel and returns nothing; a request with op
// sample returns one filtered RGBA result. One request is taken per clock
// while req_stall is low; a sample's result passes through five register
// stages (wrap, scale, index/bank read, horizontal blend, vertical blend
// and rounding). The store is split into four banks by even/odd row
// and column, so the four bilinear texels are read in the same cycle. Texels
// must be written before they are sampled. Configure only while the unit
// is idle.
module texture_sampler_wrap_bilinear #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int WEIGHT_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tsw_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tsw_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [8:0]    cfg_data
);
  import tsw_pkg::*;

  localparam int SW  = $clog2(MAX_WIDTH + 1);
  localparam int SH  = $clog2(MAX_HEIGHT + 1);
  localparam int SZW = (SW > SH) ? SW : SH;
  localparam int PW  = 13 + SZW + 1;

  logic [8:0]     tex_width, tex_height;
  logic [1:0]     wrap_mode;
  logic           filter_mode;
  logic [SZW-1:0] size_u, size_v;

  logic                   c_ready, b_valid, b_op, f_ready, d_valid, e_ready;
  logic signed [PW-1:0]   b_pu, b_pv;
  logic [7:0]             b_col, b_row;
  logic [31:0]            b_value;
  logic [3:0][31:0]       d_quad;
  logic [WEIGHT_BITS-1:0] d_fx, d_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width   <= 9'd256;
      tex_height  <= 9'd256;
      wrap_mode   <= WRAP_REPEAT;
      filter_mode <= FILTER_NEAREST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEX_WIDTH:   tex_width   <= cfg_data;
        REG_TEX_HEIGHT:  tex_height  <= cfg_data;
        REG_WRAP_MODE:   wrap_mode   <= cfg_data[1:0];
        REG_FILTER_MODE: filter_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tex_width == 9'd0) begin
      size_u = SZW'(1);
    end else if (32'(tex_width) > 32'(MAX_WIDTH)) begin
      size_u = SZW'(MAX_WIDTH);
    end else begin
      size_u = SZW'(tex_width);
    end
    if (tex_height == 9'd0) begin
      size_v = SZW'(1);
    end else if (32'(tex_height) > 32'(MAX_HEIGHT)) begin
      size_v = SZW'(MAX_HEIGHT);
    end else begin
      size_v = SZW'(tex_height);
    end
  end

  assign req_stall = !c_ready;

  tsw_coord #(.SZW(SZW), .PW(PW)) u_coord (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (c_ready),
    .in_req    (req),
    .wrap_mode (wrap_mode),
    .size_u    (size_u),
    .size_v    (size_v),
    .out_valid (b_valid),
    .out_ready (f_ready),
    .out_op    (b_op),
    .out_pu    (b_pu),
    .out_pv    (b_pv),
    .out_col   (b_col),
    .out_row   (b_row),
    .out_value (b_value)
  );

  tsw_fetch #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .WEIGHT_BITS (WEIGHT_BITS),
    .SZW         (SZW),
    .PW          (PW)
  ) u_fetch (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (b_valid),
    .in_ready    (f_ready),
    .in_op       (b_op),
    .in_pu       (b_pu),
    .in_pv       (b_pv),
    .in_col      (b_col),
    .in_row      (b_row),
    .in_value    (b_value),
    .filter_mode (filter_mode),
    .size_u      (size_u),
    .size_v      (size_v),
    .out_valid   (d_valid),
    .out_ready   (e_ready),
    .out_quad    (d_quad),
    .out_fx      (d_fx),
    .out_fy      (d_fy)
  );

  tsw_blend #(.WEIGHT_BITS(WEIGHT_BITS)) u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (e_ready),
    .in_quad   (d_quad),
    .in_fx     (d_fx),
    .in_fy     (d_fy),
    .out_valid (rsp_valid),
    .out_ready (!rsp_stall),
    .out_rsp   (rsp)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (rsp_valid && rsp_stall))
    else $error("request stalled while result side is free");

  a_size_range: assert property (@(posedge clk) disable iff (rst)
    (size_u != '0) && (32'(size_u) <= 32'(MAX_WIDTH))
    && (size_v != '0) && (32'(size_v) <= 32'(MAX_HEIGHT)))
    else $error("texture size out of range");

endmodule

[bench/texture_sampler_wrap_bilinear_test.sv]
// Testbench for the texture sampler: writes texels, samples them under
// each wrap mode, both filters and a set of sizes, and checks results
// against a local model. Depends on tsw_pkg and texture_sampler_wrap_bilinear.
module texture_sampler_wrap_bilinear_test;
  import tsw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = 256;
  localparam int MAXH = 256;
  localparam int WB   = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_t       rsp;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  texture_sampler_wrap_bilinear u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic [31:0] texels [MAXW*MAXH];
  bit          written [MAXW*MAXH];
  int unsigned cur_w = 256, cur_h = 256;
  logic [1:0]  cur_wrap = WRAP_REPEAT;
  logic        cur_filter = FILTER_NEAREST;
  rsp_t        pending_rgba [$];
  int          errors = 0;
  int          hold_cycles = 0;
  bit          stall_storm = 1'b0;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int wrapped(input logic [15:0] c);
    int v, w;
    v = $signed(c);
    if (cur_wrap == WRAP_REPEAT) w = v & 12'hfff;
    else if (cur_wrap == WRAP_MIRROR) begin
      w = (v & 16'h1fff) - COORD_ONE;
      if (w < 0) w = -w;
    end else w = v;
    if (w < 0) w = 0;
    if (w > COORD_ONE) w = COORD_ONE;
    return w;
  endfunction

  function automatic int clampi(input int i, input int sz);
    if (i < 0) return 0;
    if (i > sz - 1) return sz - 1;
    return i;
  endfunction

  function automatic void split(input int p, input int sz, output int i0, output int i1,
                                output int wt);
    int f, fr;
    f = (p >= 0) ? p / COORD_ONE : -((-p + COORD_ONE - 1) / COORD_ONE);
    fr = p - f * COORD_ONE;
    i0 = clampi(f, sz);
    i1 = clampi(f + (fr != 0), sz);
    if (p < 0) fr = 0;
    wt = fr >> (12 - WB);
  endfunction

  function automatic rsp_t filtered(input logic [15:0] u, input logic [15:0] v);
    rsp_t r;
    int px, py, x0, x1, y0, y1, fx, fy, s;
    logic [31:0] t, t00, t10, t01, t11;
    longint top, bot, sum, q;
    logic [7:0] ch [4];
    px = wrapped(u) * cur_w - COORD_HALF;
    py = wrapped(v) * cur_h - COORD_HALF;
    if (cur_filter == FILTER_NEAREST) begin
      t = texels[clampi(((py < 0 ? 0 : py) + COORD_HALF) / COORD_ONE, cur_h) * MAXW
                 + clampi(((px < 0 ? 0 : px) + COORD_HALF) / COORD_ONE, cur_w)];
      for (int c = 0; c < 4; c++) ch[c] = t[8*c +: 8];
    end else begin
      s = 1 << WB;
      split(px, cur_w, x0, x1, fx);
      split(py, cur_h, y0, y1, fy);
      t00 = texels[y0*MAXW + x0];
      t10 = texels[y0*MAXW + x1];
      t01 = texels[y1*MAXW + x0];
      t11 = texels[y1*MAXW + x1];
      for (int c = 0; c < 4; c++) begin
        top = t00[8*c +: 8] * (s - fx) + t10[8*c +: 8] * fx;
        bot = t01[8*c +: 8] * (s - fx) + t11[8*c +: 8] * fx;
        sum = top * (s - fy) + bot * fy;
        q = (sum + s * s / 2) >> (2 * WB);
        ch[c] = q > 255 ? 8'd255 : q[7:0];
      end
    end
    r.red = ch[0]; r.green = ch[1]; r.blue = ch[2]; r.alpha = ch[3];
    return r;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  bit  gaps_on = 1'b1;

  task automatic send(input req_t item);
    int g;
    g = gaps_on ? gap_len() : 0;
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (item.op == OP_WRITE) begin
      if (item.texel_col < MAXW && item.texel_row < MAXH) begin
        texels[item.texel_row*MAXW + item.texel_col] = item.texel_value;
        written[item.texel_row*MAXW + item.texel_col] = 1'b1;
      end
    end else pending_rgba.push_back(filtered(item.coord_u, item.coord_v));
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rgba.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TEX_WIDTH:  cur_w = val == 0 ? 1 : (val > MAXW ? MAXW : val);
      REG_TEX_HEIGHT: cur_h = val == 0 ? 1 : (val > MAXH ? MAXH : val);
      REG_WRAP_MODE:  cur_wrap = val[1:0];
      default:        cur_filter = val[0];
    endcase
  endtask

  task automatic configure(input int w, input int h, input int wm, input int fm);
    drain();
    set_reg(REG_TEX_WIDTH, w);
    set_reg(REG_TEX_HEIGHT, h);
    set_reg(REG_WRAP_MODE, wm);
    set_reg(REG_FILTER_MODE, fm);
  endtask

  task automatic write_texel(input int col, input int row, input logic [31:0] val);
    req_t it;
    it = '0;
    it.op = OP_WRITE;
    it.texel_col = 8'(col);
    it.texel_row = 8'(row);
    it.texel_value = val;
    it.coord_u = 16'($urandom);
    it.coord_v = 16'($urandom);
    send(it);
  endtask

  task automatic sample(input logic [15:0] u, input logic [15:0] v);
    req_t it;
    it = '0;
    it.op = OP_SAMPLE;
    it.coord_u = u;
    it.coord_v = v;
    it.texel_col = 8'($urandom);
    it.texel_row = 8'($urandom);
    it.texel_value = $urandom;
    send(it);
  endtask

  // fill the used corner of the store so any sample in it is defined
  task automatic fill(input int w, input int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if (!written[r*MAXW + c] || $urandom_range(0, 3) == 0)
          write_texel(c, r, $urandom);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 4096));
      3: return 16'(COORD_ONE * $urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] pts [8] = '{16'h0000, 16'h1000, 16'h0800, 16'h8000, 16'h7fff,
                             16'hf000, 16'h1fff, 16'h2000};
    configure(4, 4, WRAP_REPEAT, FILTER_NEAREST);
    fill(4, 4);
    write_texel(0, 0, 32'hffffffff);
    write_texel(3, 3, 32'h00000000);
    for (int m = 0; m < 4; m++) begin
      configure(4, 4, m, m & 1);
      for (int i = 0; i < 4; i++) sample(pts[$urandom_range(0, 7)], pts[2*i]);
    end
  endtask

  task automatic test_sizes();
    int sz [4][2] = '{'{1, 1}, '{256, 1}, '{1, 256}, '{3, 5}};
    for (int k = 0; k < 4; k++) begin
      configure(sz[k][0], sz[k][1], $urandom_range(0, 3), $urandom_range(0, 1));
      fill(sz[k][0], sz[k][1]);
      for (int i = 0; i < 40; i++) sample(rand_coord(), rand_coord());
    end
    // width and height above the maximum and zero saturate
    configure(0, 511, WRAP_CLAMP, FILTER_BILINEAR);
    fill(1, 256);
    for (int i = 0; i < 20; i++) sample(rand_coord(), rand_coord());
  endtask

  task automatic test_random();
    int w, h;
    for (int ph = 0; ph < 10; ph++) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      configure(w, h, $urandom_range(0, 3), $urandom_range(0, 1));
      fill(w, h);
      gaps_on = (ph % 3 != 2);
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(0, 9) == 0) write_texel($urandom, $urandom, $urandom);
        else sample(rand_coord(), rand_coord());
      end
      gaps_on = 1'b1;
    end
  endtask

  task automatic test_backpressure();
    configure(8, 8, WRAP_MIRROR, FILTER_BILINEAR);
    fill(8, 8);
    hold_cycles = 60;
    gaps_on = 1'b0;
    for (int i = 0; i < 100; i++) sample(16'($urandom), 16'($urandom));
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else if (hold_cycles > 0) begin
      rsp_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_storm) rsp_stall <= ($urandom_range(0, 9) < 7);
    else rsp_stall <= ($urandom_range(0, 9) < 2);
  end

  always @(posedge clk) begin
    if (!rst && $urandom_range(0, 199) == 0) stall_storm <= ~stall_storm;
  end

  always @(posedge clk) begin
    rsp_t exp_rgba;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rgba.size() == 0) report("result with nothing expected");
      else begin
        exp_rgba = pending_rgba.pop_front();
        if (rsp.red !== exp_rgba.red)
          report($sformatf("red %0h exp %0h", rsp.red, exp_rgba.red));
        if (rsp.green !== exp_rgba.green)
          report($sformatf("green %0h exp %0h", rsp.green, exp_rgba.green));
        if (rsp.blue !== exp_rgba.blue)
          report($sformatf("blue %0h exp %0h", rsp.blue, exp_rgba.blue));
        if (rsp.alpha !== exp_rgba.alpha)
          report($sformatf("alpha %0h exp %0h", rsp.alpha, exp_rgba.alpha));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_sizes();
    test_random();
    test_backpressure();
    drain();
    if (errors == 0) $display("texture_sampler_wrap_bilinear_test OK");
    else $display("texture_sampler_wrap_bilinear_test NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("texture_sampler_wrap_bilinear_test NOT OK");
    $finish;
  end
endmodule
